[hw/rtl/gated_median_voltage_filter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the gated median voltage filter
// Concurrent checks that drop out when the code is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef GATED_MEDIAN_VOLTAGE_FILTER_ASSERT_SVH
`define GATED_MEDIAN_VOLTAGE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that is suspended while reset is applied.
`define GMVF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gated median voltage filter check failed");

// Check that also holds while reset is applied.
`define GMVF_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gated median voltage filter check failed");

`else

`define GMVF_ASSERT(label, clk, rst_n, prop)
`define GMVF_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[hw/rtl/gmvf_pkg.sv]
// ----------------------------------------------------------------------------
// gmvf_pkg
// Shared widths, reset values, register codes and types of the filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gmvf_pkg;

  // Field widths.
  localparam int SAMPLE_W = 10;
  localparam int VOLT_W   = 16;
  localparam int PROD_W   = SAMPLE_W + VOLT_W;

  // Full-scale converter code is 2^SAMPLE_W - 1, so division by it can be
  // done with shifts and one correction.
  localparam int DIV_SHIFT = SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] FULL_CODE = {SAMPLE_W{1'b1}};

  // Default window length.
  localparam int WINDOW_DEF = 8;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] MIN_LEVEL_RESET  = '0;
  localparam logic [VOLT_W-1:0]   FULL_SCALE_RESET = 16'd4200;

  // Register indexes on the configuration port.
  localparam logic REG_MIN_LEVEL  = 1'b0;
  localparam logic REG_FULL_SCALE = 1'b1;

  // Insert request broadcast to every cell of the chain.
  typedef struct packed {
    logic                load;
    logic [SAMPLE_W-1:0] sample;
  } gmvf_ins_t;

endpackage

`default_nettype wire

[hw/rtl/gmvf_cell.sv]
// ----------------------------------------------------------------------------
// gmvf_cell
// One rank of the sorted window: a sample value and its age.
// ----------------------------------------------------------------------------
`default_nettype none

module gmvf_cell #(
  parameter int WINDOW = gmvf_pkg::WINDOW_DEF,
  parameter int AGE_W  = 3,
  parameter int INDEX  = 0
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire gmvf_pkg::gmvf_ins_t         ins,
  input  wire [gmvf_pkg::SAMPLE_W-1:0]     prev_value,
  input  wire [AGE_W-1:0]                  prev_age,
  input  wire [gmvf_pkg::SAMPLE_W-1:0]     next_value,
  input  wire [AGE_W-1:0]                  next_age,
  input  wire                              rb_in,
  output logic [gmvf_pkg::SAMPLE_W-1:0]    value,
  output logic [AGE_W-1:0]                 age,
  output logic                             rb_out
);
  import gmvf_pkg::*;

  localparam bit HAS_BELOW = (INDEX != 0);
  localparam bit HAS_HERE  = (INDEX != WINDOW - 1);
  localparam logic [AGE_W-1:0] OLDEST    = AGE_W'(WINDOW - 1);
  localparam logic [AGE_W-1:0] AGE_RESET = AGE_W'(WINDOW - 1 - INDEX);

  logic [SAMPLE_W-1:0] value_r, value_nxt;
  logic [AGE_W-1:0]    age_r, age_nxt;
  logic                del;
  logic [SAMPLE_W-1:0] here_val, below_val;
  logic [AGE_W-1:0]    here_age, below_age;
  logic                here_le, below_gt;

  // This cell holds the entry that leaves the window on the next insert.
  assign del    = (age_r == OLDEST);
  assign rb_out = rb_in | del;

  // Entry at this rank and at the rank below once the oldest is removed.
  assign here_val  = rb_out ? next_value : value_r;
  assign here_age  = rb_out ? next_age   : age_r;
  assign below_val = rb_in  ? value_r    : prev_value;
  assign below_age = rb_in  ? age_r      : prev_age;

  assign here_le  = HAS_HERE  && (here_val <= ins.sample);
  assign below_gt = HAS_BELOW && (below_val > ins.sample);

  // Keep the remaining entry, shift one in from the rank below, or take the sample.
  always_comb begin
    value_nxt = value_r;
    age_nxt   = age_r;
    if (ins.load) begin
      priority if (here_le) begin
        value_nxt = here_val;
        age_nxt   = here_age + AGE_W'(1);
      end else if (below_gt) begin
        value_nxt = below_val;
        age_nxt   = below_age + AGE_W'(1);
      end else begin
        value_nxt = ins.sample;
        age_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= '0;
      age_r   <= AGE_RESET;
    end else begin
      value_r <= value_nxt;
      age_r   <= age_nxt;
    end
  end

  assign value = value_r;
  assign age   = age_r;

endmodule

`default_nettype wire

[hw/rtl/gmvf_chain.sv]
// ----------------------------------------------------------------------------
// gmvf_chain
// Row of rank cells that keeps the window sorted and tracks entry ages.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gated_median_voltage_filter_assert.svh"

module gmvf_chain #(
  parameter int WINDOW = gmvf_pkg::WINDOW_DEF,
  parameter int AGE_W  = 3
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire gmvf_pkg::gmvf_ins_t      ins,
  output logic [gmvf_pkg::SAMPLE_W-1:0] median
);
  import gmvf_pkg::*;

  // Index 0 and WINDOW+1 are dummy neighbors beyond the ends of the row.
  logic [SAMPLE_W-1:0] vext [WINDOW+2];
  logic [AGE_W-1:0]    aext [WINDOW+2];
  logic                rb   [WINDOW+1];
  logic [WINDOW-1:0]   sorted_ok;
  logic [WINDOW-1:0]   newest_vec;

  assign vext[0]        = '0;
  assign aext[0]        = '0;
  assign vext[WINDOW+1] = '0;
  assign aext[WINDOW+1] = '0;
  assign rb[0]          = 1'b0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    gmvf_cell #(
      .WINDOW (WINDOW),
      .AGE_W  (AGE_W),
      .INDEX  (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ins        (ins),
      .prev_value (vext[i]),
      .prev_age   (aext[i]),
      .next_value (vext[i+2]),
      .next_age   (aext[i+2]),
      .rb_in      (rb[i]),
      .value      (vext[i+1]),
      .age        (aext[i+1]),
      .rb_out     (rb[i+1])
    );

    // Observation vectors for the checks below.
    assign newest_vec[i] = (aext[i+1] == '0);
    if (i == 0) begin : g_first
      assign sorted_ok[i] = 1'b1;
    end else begin : g_rest
      assign sorted_ok[i] = (vext[i] <= vext[i+1]);
    end
  end

  // The median is the middle rank of the sorted row.
  assign median = vext[WINDOW/2 + 1];

  // The row stays in ascending order.
  `GMVF_ASSERT(a_sorted, clk, rst_n, &sorted_ok)
  // Exactly one entry is the newest.
  `GMVF_ASSERT(a_newest_one, clk, rst_n, $onehot(newest_vec))
  // Some entry is always marked as the oldest.
  `GMVF_ASSERT(a_oldest_found, clk, rst_n, rb[WINDOW])

endmodule

`default_nettype wire

[hw/rtl/gmvf_scale.sv]
// ----------------------------------------------------------------------------
// gmvf_scale
// Scales a median code to median * full_scale / FULL_CODE in three steps.
// ----------------------------------------------------------------------------
`default_nettype none

module gmvf_scale (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [gmvf_pkg::SAMPLE_W-1:0]  median,
  input  wire [gmvf_pkg::VOLT_W-1:0]    full_scale,
  output logic                          done,
  output logic [gmvf_pkg::VOLT_W-1:0]   voltage
);
  import gmvf_pkg::*;

  localparam int SUM_W = PROD_W + 1;
  localparam int Q_W   = SUM_W - DIV_SHIFT;

  logic              v1_r, v2_r, done_r;
  logic [PROD_W-1:0] prod_r, prod2_r;
  logic [Q_W-1:0]    q1_r;
  logic [VOLT_W-1:0] voltage_r;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  q1_times;
  logic [SUM_W-1:0]  rem;
  logic [VOLT_W-1:0] q_fix;

  // Estimate of prod / (2^k - 1); it is low by at most one.
  assign sum = SUM_W'(prod_r) + SUM_W'(prod_r >> DIV_SHIFT)
             + SUM_W'(prod_r >> (2 * DIV_SHIFT));

  // Remainder check corrects the estimate.
  assign q1_times = (SUM_W'(q1_r) << DIV_SHIFT) - SUM_W'(q1_r);
  assign rem      = SUM_W'(prod2_r) - q1_times;
  assign q_fix    = (rem >= SUM_W'(FULL_CODE)) ? VOLT_W'(q1_r + Q_W'(1)) : VOLT_W'(q1_r);

  // Step control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // Product, estimate and corrected quotient.
  always_ff @(posedge clk) begin
    prod_r    <= PROD_W'(median) * PROD_W'(full_scale);
    prod2_r   <= prod_r;
    q1_r      <= Q_W'(sum >> DIV_SHIFT);
    voltage_r <= q_fix;
  end

  assign done    = done_r;
  assign voltage = voltage_r;

endmodule

`default_nettype wire

[hw/rtl/gated_median_voltage_filter.sv]
// ----------------------------------------------------------------------------
// gated_median_voltage_filter
// Gated sliding-window median filter with scaling to a voltage.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one converter sample on in_adc_sample. Each request
//   gives exactly one result request with out_voltage and out_sample_taken.
//   A sample at or below the minimum level is rejected; its result carries
//   the held voltage in the cycle after acceptance, and the block is ready
//   again in the next cycle unless the receiver stalls. An accepted sample
//   replaces the oldest window entry in the cell row at the acceptance edge,
//   then the median is scaled in a three-step multiply and divide unit; the
//   next sample can be taken when its result appears, unless the receiver
//   stalls, so that scaling unit sets the rate. Write the registers through
//   the APB-style port only while idle; the block itself does not enforce this.
//   Reset clears the window to zeros, the held voltage to zero and loads
//   the register defaults. While the receiver stalls, the result stays in
//   the output register and in_stall holds off further requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gated_median_voltage_filter_assert.svh"

module gated_median_voltage_filter #(
  parameter int WINDOW_SIZE = gmvf_pkg::WINDOW_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  // Sample channel
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire [gmvf_pkg::SAMPLE_W-1:0]  in_adc_sample,
  // Result channel
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [gmvf_pkg::VOLT_W-1:0]   out_voltage,
  output logic                          out_sample_taken,
  // Configuration port
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire [2:0]                     paddr,
  input  wire [31:0]                    pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gmvf_pkg::*;

  localparam int AGE_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_BUSY  = 2'd2;
  localparam logic [1:0] S_PEND  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [SAMPLE_W-1:0] min_r;
  logic [VOLT_W-1:0]   fs_r;
  logic [VOLT_W-1:0]   held_r;
  logic                out_valid_r;
  logic [VOLT_W-1:0]   out_voltage_r;
  logic                out_taken_r;

  logic                in_accept, taken, out_free;
  logic                rej_load, pend_load, cfg_write;
  logic                reg_idx;
  gmvf_ins_t           ins;
  logic [SAMPLE_W-1:0] median;
  logic                scale_done;
  logic [VOLT_W-1:0]   scale_voltage;

  // Configuration registers.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[2];
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= MIN_LEVEL_RESET;
      fs_r  <= FULL_SCALE_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MIN_LEVEL:  min_r <= pwdata[SAMPLE_W-1:0];
        REG_FULL_SCALE: fs_r  <= pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_LEVEL:  prdata = 32'(min_r);
      REG_FULL_SCALE: prdata = 32'(fs_r);
      default:        prdata = '0;
    endcase
  end

  // Input handshake and gating.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign taken     = (in_adc_sample > min_r);
  assign rej_load  = in_accept && !taken;
  assign pend_load = (state_r == S_PEND) && out_free;

  assign ins.load   = in_accept && taken;
  assign ins.sample = in_adc_sample;

  gmvf_chain #(
    .WINDOW (WINDOW_SIZE),
    .AGE_W  (AGE_W)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ins    (ins),
    .median (median)
  );

  gmvf_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (state_r == S_ISSUE),
    .median     (median),
    .full_scale (fs_r),
    .done       (scale_done),
    .voltage    (scale_voltage)
  );

  // Sequencer for a taken sample.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (ins.load) state_nxt = S_ISSUE;
      S_ISSUE: state_nxt = S_BUSY;
      S_BUSY:  if (scale_done) state_nxt = S_PEND;
      S_PEND:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (scale_done) begin
        held_r <= scale_voltage;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rej_load || pend_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rej_load || pend_load) begin
      out_voltage_r <= held_r;
      out_taken_r   <= pend_load;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_voltage      = out_voltage_r;
  assign out_sample_taken = out_taken_r;

  // No request is taken while a sample is being processed.
  `GMVF_ASSERT(a_busy_stall, clk, rst_n, (state_r != S_IDLE) |-> in_stall)
  // A rejected sample returns the held voltage in the next cycle.
  `GMVF_ASSERT(a_reject_result, clk, rst_n,
    rej_load |=> (out_valid && !out_sample_taken && (out_voltage == $past(held_r))))
  // A scaled median never exceeds the full-scale voltage.
  `GMVF_ASSERT(a_scale_bound, clk, rst_n, scale_done |-> (scale_voltage <= fs_r))

endmodule

`default_nettype wire
